// ===== rtl/core/psg_pkg.sv =====
// package for the tone/noise sound generator
// types, channel entry layout, attenuation table and sequencer states; no dependencies
package psg_pkg;

   localparam int unsigned CLK_RATE_W   = 24;
   localparam int unsigned SMP_RATE_W   = 18;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam int unsigned FRAC_W       = 25;
   localparam int unsigned DEN_W        = 22;
   localparam int unsigned PERIOD_W     = 10;
   localparam int unsigned ATTEN_W      = 4;
   localparam int unsigned LFSR_W       = 16;
   localparam int unsigned CHAN_NUM     = 4;
   localparam int unsigned CHAN_W       = 2;
   localparam int unsigned SAMPLE_W     = 32;

   localparam logic [CHAN_W-1:0]   NOISE_CHAN  = 2'd3;
   localparam logic [CHAN_W-1:0]   TONE2_CHAN  = 2'd2;
   localparam logic [LFSR_W-1:0]   LFSR_SEED   = 16'h8000;
   localparam logic [PERIOD_W-1:0] NOISE_BASE  = 10'h020;
   localparam logic [1:0]          RATE_TONE2  = 2'd3;
   localparam logic                CSR_CLK_RATE = 1'b0;
   localparam logic                CSR_SMP_RATE = 1'b1;

   localparam logic [CLK_RATE_W-1:0] CLK_RATE_RST = 24'd3579545;
   localparam logic [SMP_RATE_W-1:0] SMP_RATE_RST = 18'd44100;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [ATTEN_W-1:0]  atten;
      logic [PERIOD_W-1:0] count;
      logic                level;
   } chan_entry_type;

   localparam int unsigned ENTRY_W = $bits(chan_entry_type);

   localparam chan_entry_type ENTRY_RST = '{period: '0, atten: 4'hF,
                                            count: 10'd1, level: 1'b0};

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic [SAMPLE_W-1:0] mix_in;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_CHECK,
      ST_TICK_MOD,
      ST_MIX_MOD,
      ST_DONE
   } seq_state_type;

   function automatic logic [13:0] atten_level(input logic [ATTEN_W-1:0] att);
      logic [13:0] lvl;
      unique case (att)
         4'd0:  lvl = 14'd8191;
         4'd1:  lvl = 14'd6507;
         4'd2:  lvl = 14'd5168;
         4'd3:  lvl = 14'd4105;
         4'd4:  lvl = 14'd3261;
         4'd5:  lvl = 14'd2590;
         4'd6:  lvl = 14'd2057;
         4'd7:  lvl = 14'd1634;
         4'd8:  lvl = 14'd1298;
         4'd9:  lvl = 14'd1031;
         4'd10: lvl = 14'd819;
         4'd11: lvl = 14'd650;
         4'd12: lvl = 14'd516;
         4'd13: lvl = 14'd410;
         4'd14: lvl = 14'd325;
         default: lvl = 14'd0;
      endcase
      return lvl;
   endfunction

endpackage

// ===== rtl/core/psg_chan_if.sv =====
// valid/ready channel carrying one transaction payload
// depends on nothing; payload type is set by the instantiating level
interface psg_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/psg_tone_noise_generator_top.sv =====
// top level of the three-tone, one-noise sound generator
// depends on psg_pkg, psg_chan_if and psg_ram
//
// req_chan carries one transaction per item: mode 0 writes a latch/data byte,
// mode 1 asks for one sample, returned on rsp_chan as mix_in plus the four
// channel levels (wrapping at 32 bits). writes give no response.
// csr_we/csr_index/csr_wdata set the chip clock rate (index 0) and the output
// sample rate (index 1); the user must write them only while the block is
// idle, as the block itself does not enforce it. channel state (period,
// attenuation, counter, level) lives in a four-entry ram read in the cycle
// before each read-modify-write; the noise lfsr and control sit in flops.
// a write reads its ram entry, then writes it back. a sample first crosses the
// internal ticks due (clock rate over sixteen times sample rate): each tick is
// one check step plus a read-modify-write of each ram entry in turn; then come
// a final check, four mix steps and a step loading the output register. with a
// zero sample rate no ticks are crossed and the sample goes straight to mixing.
// one item is worked at a time; req ready is high only while idle, and a new
// item is taken while an earlier response still waits in the output register.
// a finished sample waits for that register if the receiver stalls.
// synchronous reset restores all but the byte, accumulator and output data
// flops; entries unwritten since reset read as reset via per-entry valid flags.
module psg_tone_noise_generator_top (
   input  logic                  clock,
   input  logic                  reset,
   psg_chan_if.sink              req_chan,
   psg_chan_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [psg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import psg_pkg::*;

   seq_state_type             state_ff, state_in;
   logic [CLK_RATE_W-1:0]     clk_rate_ff;
   logic [SMP_RATE_W-1:0]     smp_rate_ff;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [CHAN_W-1:0]         idx_ff, idx_in;
   logic [7:0]                byte_ff, byte_in;
   logic [SAMPLE_W-1:0]       acc_ff, acc_in;
   logic [SAMPLE_W-1:0]       out_ff, out_in;
   logic                      out_vld_ff, out_vld_in;
   logic [CHAN_W-1:0]         latch_ch_ff, latch_ch_in;
   logic                      latch_att_ff, latch_att_in;
   logic                      white_ff, white_in;
   logic [1:0]                rate_sel_ff, rate_sel_in;
   logic [LFSR_W-1:0]         lfsr_ff, lfsr_in;
   logic [PERIOD_W-1:0]       tone2_per_ff, tone2_per_in;
   logic [CHAN_NUM-1:0]       vld_ff, vld_in;
   logic                      rd_vld_ff, rd_vld_in;

   logic                      ram_we;
   logic [CHAN_W-1:0]         ram_rd_addr;
   logic [ENTRY_W-1:0]        ram_rd_data;
   chan_entry_type            ent, ent_new;
   logic [DEN_W-1:0]          den;
   logic                      req_fire;
   logic [CHAN_W-1:0]         req_ch;
   logic                      w_latch, w_att;
   logic [CHAN_W-1:0]         w_ch;
   logic [PERIOD_W-1:0]       cnt_dec, reload_per;
   logic [SAMPLE_W-1:0]       lvl_mag, lvl_signed;
   logic                      lvl_bit;

   psg_ram #(.WIDTH(ENTRY_W), .DEPTH(CHAN_NUM)) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ent_new),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ent      = rd_vld_ff ? chan_entry_type'(ram_rd_data) : ENTRY_RST;
   assign den      = {smp_rate_ff, 4'b0000};
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.payload.sample_out = out_ff;
   assign req_ch   = req_chan.payload.data_byte[7] ? req_chan.payload.data_byte[6:5]
                                                   : latch_ch_ff;

   assign w_latch  = byte_ff[7];
   assign w_ch     = w_latch ? byte_ff[6:5] : latch_ch_ff;
   assign w_att    = w_latch ? byte_ff[4] : latch_att_ff;

   assign cnt_dec  = ent.count - 10'd1;
   assign lvl_mag  = {18'd0, atten_level(ent.atten)};
   assign lvl_bit  = (idx_ff == NOISE_CHAN) ? lfsr_ff[0] : ent.level;
   assign lvl_signed = lvl_bit ? lvl_mag : (SAMPLE_W'(0) - lvl_mag);

   always_comb begin
      if (idx_ff == NOISE_CHAN) begin
         reload_per = (rate_sel_ff == RATE_TONE2) ? tone2_per_ff
                                                  : (NOISE_BASE << rate_sel_ff);
      end else begin
         reload_per = ent.period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_rate_ff  <= CLK_RATE_RST;
         smp_rate_ff  <= SMP_RATE_RST;
         frac_ff      <= '0;
         out_vld_ff   <= 1'b0;
         latch_ch_ff  <= '0;
         latch_att_ff <= 1'b0;
         white_ff     <= 1'b0;
         rate_sel_ff  <= '0;
         lfsr_ff      <= LFSR_SEED;
         tone2_per_ff <= '0;
         vld_ff       <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frac_ff      <= frac_in;
         out_vld_ff   <= out_vld_in;
         latch_ch_ff  <= latch_ch_in;
         latch_att_ff <= latch_att_in;
         white_ff     <= white_in;
         rate_sel_ff  <= rate_sel_in;
         lfsr_ff      <= lfsr_in;
         tone2_per_ff <= tone2_per_in;
         vld_ff       <= vld_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CLK_RATE: clk_rate_ff <= csr_wdata[CLK_RATE_W-1:0];
               CSR_SMP_RATE: smp_rate_ff <= csr_wdata[SMP_RATE_W-1:0];
               default: ;
            endcase
         end
      end
      byte_ff <= byte_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      frac_in      = frac_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_chan.ready;
      latch_ch_in  = latch_ch_ff;
      latch_att_in = latch_att_ff;
      white_in     = white_ff;
      rate_sel_in  = rate_sel_ff;
      lfsr_in      = lfsr_ff;
      tone2_per_in = tone2_per_ff;
      vld_in       = vld_ff;
      ram_we       = 1'b0;
      ram_rd_addr  = '0;
      ent_new      = ent;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in = req_chan.payload.data_byte;
               acc_in  = req_chan.payload.mix_in;
               if (!req_chan.payload.mode) begin
                  idx_in      = req_ch;
                  ram_rd_addr = req_ch;
                  state_in    = ST_WR_MOD;
               end else if (den == '0) begin
                  frac_in     = '0;
                  idx_in      = '0;
                  state_in    = ST_MIX_MOD;
               end else begin
                  frac_in  = frac_ff + FRAC_W'(clk_rate_ff);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_WR_MOD: begin
            latch_ch_in  = w_ch;
            latch_att_in = w_att;
            ram_we       = 1'b1;
            vld_in[idx_ff] = 1'b1;
            if (w_att) begin
               ent_new.atten = byte_ff[3:0];
            end else if (w_ch == NOISE_CHAN) begin
               white_in    = byte_ff[2];
               rate_sel_in = byte_ff[1:0];
               lfsr_in     = LFSR_SEED;
            end else begin
               ent_new.period = w_latch ? {ent.period[9:4], byte_ff[3:0]}
                                        : {byte_ff[5:0], ent.period[3:0]};
               if (w_ch == TONE2_CHAN) begin
                  tone2_per_in = ent_new.period;
               end
            end
            state_in = ST_IDLE;
         end
         ST_CHECK: begin
            idx_in = '0;
            if (frac_ff >= FRAC_W'(den)) begin
               frac_in  = frac_ff - FRAC_W'(den);
               state_in = ST_TICK_MOD;
            end else begin
               state_in = ST_MIX_MOD;
            end
         end
         ST_TICK_MOD: begin
            ram_we = 1'b1;
            vld_in[idx_ff] = 1'b1;
            ent_new.count = cnt_dec;
            if (cnt_dec == '0) begin
               ent_new.count = (reload_per == '0) ? 10'd1 : reload_per;
               ent_new.level = ~ent.level;
               if (idx_ff == NOISE_CHAN) begin
                  lfsr_in = {white_ff ? (lfsr_ff[0] ^ lfsr_ff[3]) : lfsr_ff[0],
                             lfsr_ff[15:1]};
               end
            end
            idx_in      = idx_ff + 2'd1;
            ram_rd_addr = idx_ff + 2'd1;
            if (idx_ff == NOISE_CHAN) begin
               state_in = ST_CHECK;
            end
         end
         ST_MIX_MOD: begin
            acc_in      = acc_ff + lvl_signed;
            idx_in      = idx_ff + 2'd1;
            ram_rd_addr = idx_ff + 2'd1;
            if (idx_ff == NOISE_CHAN) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_chan.ready) begin
               out_in     = acc_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_CHECK) begin
         ram_rd_addr = '0;
      end
      rd_vld_in = vld_in[ram_rd_addr] && !(ram_we && (idx_ff == ram_rd_addr)) ||
                  vld_ff[ram_rd_addr];
   end
endmodule

// ===== rtl/core/psg_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
module psg_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
